[rtl/apv_frame_stream_deframer_core_macros.svh]
// Assertion macros shared by the checkers of the deframer.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef APV_FRAME_STREAM_DEFRAMER_CORE_MACROS_SVH
`define APV_FRAME_STREAM_DEFRAMER_CORE_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define APVD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer check failed: next-cycle property");

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define APVD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer check failed: same-cycle property");

// Next-cycle property that is also checked while reset is applied.
`define APVD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("deframer check failed: reset property");

`endif

[rtl/apvd_pkg.sv]
// Types and constants of the APV frame stream deframer.
// Used by every module of the block; depends on nothing.
package apvd_pkg;

    localparam int unsigned CHANNELS       = 16;
    localparam int unsigned MODULES        = 16;
    localparam int unsigned MASK_REGS      = 4;
    localparam int unsigned MASK_W         = 64;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned OUTQ_DEPTH_DEF = 4;

    localparam logic [31:0] END_MARK        = 32'hfafa_fafa;
    localparam logic [23:0] FRAME_TAG       = 24'h41_4443;
    localparam logic [15:0] SIZE_RESET      = 16'd4000;
    localparam logic [2:0]  HDR_WORDS       = 3'd7;
    localparam logic [2:0]  HDR_MODULE_WORD = 3'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MASK_MODS_0_3   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_MODS_4_7   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_MODS_8_11  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_MODS_12_15 = 2'd3;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_COMMIT   = 2'd1,
        KIND_DISCARD  = 2'd2,
        KIND_CHAN_ERR = 2'd3
    } t_kind;

    typedef struct packed {
        logic [31:0] buffer_word;
        logic        first_word;
        logic        final_word;
    } t_in_item;

    typedef struct packed {
        t_kind       item_kind;
        logic [31:0] payload_word;
        logic [7:0]  module_id;
        logic [7:0]  channel_no;
        logic [15:0] frame_size;
        logic        run_end;
    } t_out_item;

    // Up to two results from one input word, packed from index 0.
    typedef struct packed {
        logic [1:0]           count;
        t_out_item [1:0]      item;
    } t_dec_res;

    typedef logic [MASK_REGS-1:0][MASK_W-1:0] t_masks;

endpackage

[rtl/apvd_cfg.sv]
// Active channel mask registers of the deframer.
// Depends on apvd_pkg.
module apvd_cfg
    import apvd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MASK_W-1:0]    i_cfg_data,
    output t_masks               o_masks
);

    t_masks r_masks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_masks <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MASK_MODS_0_3:   r_masks[0] <= i_cfg_data;
                REG_MASK_MODS_4_7:   r_masks[1] <= i_cfg_data;
                REG_MASK_MODS_8_11:  r_masks[2] <= i_cfg_data;
                REG_MASK_MODS_12_15: r_masks[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_masks = r_masks;

endmodule

[rtl/apvd_decode.sv]
// Frame decoder: deframer state and per-word result generation.
// Depends on apvd_pkg; results go to the output queue.
module apvd_decode
    import apvd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    input  t_masks   i_masks,
    output t_dec_res o_res
);

    logic [2:0]  r_hdr_cnt,  n_hdr_cnt;
    logic [7:0]  r_module,   n_module;
    logic [7:0]  r_channel,  n_channel;
    logic        r_exp_size, n_exp_size;
    logic [31:0] r_held,     n_held;
    logic        r_held_vld, n_held_vld;
    logic        r_has_data, n_has_data;
    logic [15:0] r_size,     n_size;
    logic        r_stopped,  n_stopped;

    t_dec_res res;

    function automatic logic chan_on(logic [7:0] mod, logic [7:0] ch, t_masks masks);
        logic [5:0] sh;
        logic       bit_on;
        sh     = {mod[1:0], ch[3:0]};
        bit_on = masks[mod[3:2]][sh];
        return (mod < 8'(MODULES)) && (ch < 8'(CHANNELS)) && bit_on;
    endfunction

    function automatic t_out_item mk(t_kind kind, logic [31:0] payload, logic [7:0] mod,
                                     logic [7:0] ch, logic [15:0] size);
        t_out_item it;
        it.item_kind    = kind;
        it.payload_word = payload;
        it.module_id    = mod;
        it.channel_no   = ch;
        it.frame_size   = size;
        it.run_end      = 1'b0;
        return it;
    endfunction

    always_comb begin
        logic        act;
        logic [31:0] w;
        // A first word restarts the deframer before the word is looked at.
        n_hdr_cnt  = i_item.first_word ? 3'd0       : r_hdr_cnt;
        n_module   = i_item.first_word ? 8'd0       : r_module;
        n_channel  = i_item.first_word ? 8'd0       : r_channel;
        n_exp_size = i_item.first_word ? 1'b0       : r_exp_size;
        n_held     = i_item.first_word ? 32'd0      : r_held;
        n_held_vld = i_item.first_word ? 1'b0       : r_held_vld;
        n_has_data = i_item.first_word ? 1'b0       : r_has_data;
        n_size     = i_item.first_word ? SIZE_RESET : r_size;
        n_stopped  = i_item.first_word ? 1'b0       : r_stopped;
        w          = i_item.buffer_word;
        res        = '0;
        // Channel changes only where no further result follows, so one lookup serves.
        act        = chan_on(n_module, n_channel, i_masks);

        if (!n_stopped) begin
            if (n_hdr_cnt < HDR_WORDS) begin
                if (n_hdr_cnt == HDR_MODULE_WORD) begin
                    n_module = w[7:0];
                end
                n_hdr_cnt = n_hdr_cnt + 3'd1;
            end else if (w == END_MARK) begin
                if (n_held_vld && act) begin
                    res.item[res.count[0]] = mk(KIND_DATA, n_held, n_module, n_channel, n_size);
                    res.count = res.count + 2'd1;
                end
                if ((n_held_vld || n_has_data) && act) begin
                    res.item[res.count[0]] = mk(KIND_COMMIT, 32'd0, n_module, n_channel, n_size);
                    res.count = res.count + 2'd1;
                end
                n_held_vld = 1'b0;
                n_has_data = 1'b0;
                n_channel  = 8'd0;
                n_stopped  = 1'b1;
            end else if (n_exp_size) begin
                n_size     = w[15:0];
                n_held_vld = 1'b0;
                n_has_data = 1'b0;
                n_exp_size = 1'b0;
            end else if (w[31:8] == FRAME_TAG) begin
                // The word held before a header is padding and is dropped.
                n_held_vld = 1'b0;
                if (n_has_data && act) begin
                    res.item[res.count[0]] = mk(KIND_COMMIT, 32'd0, n_module, n_channel, n_size);
                    res.count = res.count + 2'd1;
                end
                n_has_data = 1'b0;
                n_channel  = w[7:0];
                if (w[7:0] > 8'(CHANNELS - 1)) begin
                    res.item[res.count[0]] = mk(KIND_CHAN_ERR, 32'd0, n_module, n_channel,
                                                n_size);
                    res.count = res.count + 2'd1;
                    n_stopped = 1'b1;
                end else begin
                    n_exp_size = 1'b1;
                end
            end else begin
                if (n_held_vld) begin
                    if (act) begin
                        res.item[res.count[0]] = mk(KIND_DATA, n_held, n_module, n_channel,
                                                    n_size);
                        res.count = res.count + 2'd1;
                    end
                    n_has_data = 1'b1;
                end
                n_held     = w;
                n_held_vld = 1'b1;
            end

            if (i_item.final_word && !n_stopped) begin
                if ((n_held_vld || n_has_data) && act) begin
                    res.item[res.count[0]] = mk(KIND_DISCARD, 32'd0, n_module, n_channel, n_size);
                    res.count = res.count + 2'd1;
                end
                n_held_vld = 1'b0;
                n_has_data = 1'b0;
                n_stopped  = 1'b1;
            end
        end

        if (res.count == 2'd1) begin
            res.item[0].run_end = 1'b1;
        end else if (res.count == 2'd2) begin
            res.item[1].run_end = 1'b1;
        end
        if (!i_accept) begin
            res.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt  <= 3'd0;
            r_module   <= 8'd0;
            r_channel  <= 8'd0;
            r_exp_size <= 1'b0;
            r_held     <= 32'd0;
            r_held_vld <= 1'b0;
            r_has_data <= 1'b0;
            r_size     <= SIZE_RESET;
            r_stopped  <= 1'b0;
        end else if (i_accept) begin
            r_hdr_cnt  <= n_hdr_cnt;
            r_module   <= n_module;
            r_channel  <= n_channel;
            r_exp_size <= n_exp_size;
            r_held     <= n_held;
            r_held_vld <= n_held_vld;
            r_has_data <= n_has_data;
            r_size     <= n_size;
            r_stopped  <= n_stopped;
        end
    end

    assign o_res = res;

endmodule

[rtl/apvd_outq.sv]
// Result queue of the deframer: takes up to two results a cycle, gives one while not stalled.
// Depends on apvd_pkg.
module apvd_outq
    import apvd_pkg::*;
#(
    parameter int unsigned DEPTH = OUTQ_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dec_res  i_res,
    output logic      o_full,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_out_item        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] wr_next;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign wr_next = ptr_inc(r_wr);
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_wr = r_wr;
        if (i_res.count == 2'd1) begin
            n_wr = wr_next;
        end else if (i_res.count == 2'd2) begin
            n_wr = ptr_inc(wr_next);
        end
        n_rd    = pop ? ptr_inc(r_rd) : r_rd;
        n_count = r_count + CNT_W'(i_res.count) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_res.count != 2'd0) begin
            r_mem[r_wr] <= i_res.item[0];
        end
        if (i_res.count == 2'd2) begin
            r_mem[wr_next] <= i_res.item[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Room for two results must exist before a word is taken.
    assign o_full  = r_count > CNT_W'(DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];

endmodule

[rtl/apv_frame_stream_deframer_core.sv]
// Top level of the APV frame stream deframer.
// Depends on apvd_pkg, apvd_cfg, apvd_decode and apvd_outq.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_stall    i_in_item  (t_in_item)
//   output    out        o_out_valid / i_out_stall  o_out_item (t_out_item)
//   config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// One word is taken per unstalled cycle; its results are in the queue the next cycle.
// A word yields zero to two results; the output drains one result per unstalled cycle,
// so the sustained rate is one word per cycle while words average at most one result.
// The input stalls while the result queue has room for fewer than two results.
// Reset is synchronous and active low; it clears the masks and the frame state.
module apv_frame_stream_deframer_core
    import apvd_pkg::*;
#(
    parameter int unsigned OUTQ_DEPTH = OUTQ_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MASK_W-1:0]    i_cfg_data
);

    t_masks   masks;
    t_dec_res res;
    logic     full;
    logic     accept;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    apvd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_masks     (masks)
    );

    apvd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .i_masks  (masks),
        .o_res    (res)
    );

    apvd_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_full  (full),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_stall (i_out_stall)
    );

endmodule

[rtl/apvd_checker.sv]
// Port-level checks of the deframer top level, bound to it below.
// Depends on apvd_pkg and the assertion macro header.
`include "apv_frame_stream_deframer_core_macros.svh"

module apvd_checker
    import apvd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    `APVD_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `APVD_ASSERT_NEXT(a_out_item_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_item))
    `APVD_ASSERT_NEXT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)
    `APVD_ASSERT_NOW(a_empty_never_stalls, i_clk, i_rst_n, !o_out_valid, !o_in_stall)

endmodule

bind apv_frame_stream_deframer_core apvd_checker u_apvd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

[tb/tb_apv_frame_stream_deframer_core.sv]
// Testbench of the APV frame stream deframer core: short directed buffers, then random
// buffers under several channel mask settings, checked against an in-bench deframer model.
// Depends on apvd_pkg and apv_frame_stream_deframer_core.
module tb_apv_frame_stream_deframer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import apvd_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_WORDS = 1500;
    localparam int MASK_PHASES  = 6;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_item             in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_item;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_MASK_MODS_0_3;
    logic [MASK_W-1:0]    cfg_data = '0;

    // Model of the deframer state and of the channel masks.
    t_masks      mask_copy;
    logic [2:0]  hdr_seen;
    logic [7:0]  mod_id;
    logic [7:0]  chan;
    logic        want_size;
    logic [31:0] held;
    logic        held_ok;
    logic        has_data;
    logic [15:0] pkt_size;
    logic        halted;

    t_out_item pending_results[$];
    t_out_item oldest;
    int        results_this_word;
    int        errors = 0;
    int        words_sent = 0;
    int        idle_cycles = 0;
    bit        no_idle = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    apv_frame_stream_deframer_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    function automatic void restart_frame();
        hdr_seen  = '0;
        mod_id    = '0;
        chan      = '0;
        want_size = 1'b0;
        held      = '0;
        held_ok   = 1'b0;
        has_data  = 1'b0;
        pkt_size  = SIZE_RESET;
        halted    = 1'b0;
    endfunction

    function automatic logic channel_enabled();
        int bit_pos;
        if (mod_id > 8'd15 || chan >= CHANNELS) begin
            return 1'b0;
        end
        bit_pos = int'(mod_id[1:0]) * 16 + int'(chan[3:0]);
        return mask_copy[mod_id[3:2]][bit_pos];
    endfunction

    function automatic void emit(t_kind kind, logic [31:0] payload);
        t_out_item r;
        r.item_kind    = kind;
        r.payload_word = payload;
        r.module_id    = mod_id;
        r.channel_no   = chan;
        r.frame_size   = pkt_size;
        r.run_end      = 1'b0;
        pending_results.insert(pending_results.size(), r);
        results_this_word++;
    endfunction

    // Advances the model by one buffer word and queues the results it causes.
    function automatic void deframe_word(t_in_item it);
        logic      act;
        t_out_item last_res;
        results_this_word = 0;
        if (it.first_word) begin
            restart_frame();
        end
        if (halted) begin
            return;
        end
        if (hdr_seen < HDR_WORDS) begin
            if (hdr_seen == HDR_MODULE_WORD) begin
                mod_id = it.buffer_word[7:0];
            end
            hdr_seen++;
        end else if (it.buffer_word == END_MARK) begin
            act = channel_enabled();
            if (held_ok && act) begin
                emit(KIND_DATA, held);
            end
            if ((held_ok || has_data) && act) begin
                emit(KIND_COMMIT, '0);
            end
            held_ok  = 1'b0;
            has_data = 1'b0;
            chan     = '0;
            halted   = 1'b1;
        end else if (want_size) begin
            pkt_size  = it.buffer_word[15:0];
            held_ok   = 1'b0;
            has_data  = 1'b0;
            want_size = 1'b0;
        end else if (it.buffer_word[31:8] == FRAME_TAG) begin
            // The word held back just before a header is dropped.
            held_ok = 1'b0;
            if (has_data && channel_enabled()) begin
                emit(KIND_COMMIT, '0);
            end
            has_data = 1'b0;
            chan = it.buffer_word[7:0];
            if (chan > CHANNELS - 1) begin
                emit(KIND_CHAN_ERR, '0);
                halted = 1'b1;
            end else begin
                want_size = 1'b1;
            end
        end else begin
            if (held_ok) begin
                if (channel_enabled()) begin
                    emit(KIND_DATA, held);
                end
                has_data = 1'b1;
            end
            held    = it.buffer_word;
            held_ok = 1'b1;
        end
        if (it.final_word && !halted) begin
            if ((held_ok || has_data) && channel_enabled()) begin
                emit(KIND_DISCARD, '0);
            end
            held_ok  = 1'b0;
            has_data = 1'b0;
            halted   = 1'b1;
        end
        if (results_this_word > 0) begin
            last_res = pending_results[pending_results.size() - 1];
            last_res.run_end = 1'b1;
            pending_results[pending_results.size() - 1] = last_res;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < 25);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with none expected: kind %0d, payload %0h",
                       out_item.item_kind, out_item.payload_word);
                errors++;
            end else begin
                oldest = pending_results.pop_front();
                check_field("item_kind", oldest.item_kind, out_item.item_kind);
                check_field("payload_word", oldest.payload_word, out_item.payload_word);
                check_field("module_id", oldest.module_id, out_item.module_id);
                check_field("channel_no", oldest.channel_no, out_item.channel_no);
                check_field("frame_size", oldest.frame_size, out_item.frame_size);
                check_field("run_end", oldest.run_end, out_item.run_end);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Presents one word and holds it until the block takes the request.
    task automatic send_word(input logic [31:0] word, input logic first, input logic last);
        t_in_item it;
        it.buffer_word = word;
        it.first_word  = first;
        it.final_word  = last;
        while (!no_idle && $urandom_range(0, 99) < 25) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall);
        deframe_word(it);
        words_sent++;
    endtask

    task automatic send_header(input logic [7:0] module_no);
        logic [31:0] w;
        for (int k = 0; k < int'(HDR_WORDS); k++) begin
            w = $urandom;
            if (k == int'(HDR_MODULE_WORD)) begin
                w[7:0] = module_no;
            end
            send_word(w, k == 0, 1'b0);
        end
    endtask

    // Mostly plain data, with an occasional early end, stray header or buffer flag.
    task automatic send_data();
        logic [31:0] w;
        case ($urandom_range(0, 31))
            0: w = '0;
            1: w = '1;
            2: w = END_MARK;
            3: w = {FRAME_TAG, 4'h0, 4'($urandom)};
            default: w = $urandom;
        endcase
        send_word(w, $urandom_range(0, 149) == 0, $urandom_range(0, 99) == 0);
    endtask

    task automatic send_random_buffer();
        int          frames;
        int          ending;
        logic [7:0]  mod_no;
        logic [7:0]  ch;
        mod_no = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        send_header(mod_no);
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_data();
        end
        frames = $urandom_range(0, 4);
        repeat (frames) begin
            ch = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
            send_word({FRAME_TAG, ch}, 1'b0, 1'b0);
            send_word($urandom, 1'b0, 1'b0);
            repeat ($urandom_range(0, 6)) send_data();
        end
        // Most buffers close with the end marker; some are cut by the last-word flag,
        // and the rest simply run into the next buffer.
        ending = $urandom_range(0, 9);
        if (ending < 6) begin
            send_word(END_MARK, 1'b0, 1'b0);
        end else if (ending < 8) begin
            send_word($urandom, 1'b0, 1'b1);
        end
        if ($urandom_range(0, 3) == 0) begin
            send_data();
        end
    endtask

    // Returns once every expected result has come and the pipeline has emptied.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_masks(input t_masks m);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MASK_MODS_0_3;
        cfg_data  <= m[REG_MASK_MODS_0_3];
        @(posedge i_clk);
        cfg_index <= REG_MASK_MODS_4_7;
        cfg_data  <= m[REG_MASK_MODS_4_7];
        @(posedge i_clk);
        cfg_index <= REG_MASK_MODS_8_11;
        cfg_data  <= m[REG_MASK_MODS_8_11];
        @(posedge i_clk);
        cfg_index <= REG_MASK_MODS_12_15;
        cfg_data  <= m[REG_MASK_MODS_12_15];
        @(posedge i_clk);
        cfg_we <= 1'b0;
        mask_copy = m;
    endtask

    // Data ahead of any header, a commit on a new header, an empty frame and the end marker.
    task automatic test_frame_sequence();
        set_masks('1);
        send_header(8'd5);
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'hffff_ffff, 1'b0, 1'b0);
        send_word({FRAME_TAG, 8'd3}, 1'b0, 1'b0);
        send_word(32'h0000_ffff, 1'b0, 1'b0);
        send_word({FRAME_TAG, 8'd15}, 1'b0, 1'b0);
        send_word(32'habcd_0010, 1'b0, 1'b0);
        send_word(32'h1111_1111, 1'b0, 1'b0);
        send_word(32'h2222_2222, 1'b0, 1'b0);
        send_word(END_MARK, 1'b0, 1'b0);
        send_word(32'h1234_5678, 1'b0, 1'b0);
        settle();
    endtask

    // A module id with no mask, then a channel number out of range.
    task automatic test_channel_error();
        send_header(8'h9a);
        send_word(32'h5a5a_5a5a, 1'b0, 1'b0);
        send_word({FRAME_TAG, 8'h10}, 1'b0, 1'b0);
        settle();
    endtask

    // The buffer ends without a marker, so the open frame is discarded.
    task automatic test_buffer_cut();
        send_header(8'd15);
        send_word({FRAME_TAG, 8'd0}, 1'b0, 1'b0);
        send_word(32'h0000_0007, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'hffff_ffff, 1'b0, 1'b1);
        settle();
    endtask

    task automatic test_random_masks();
        t_masks m;
        int     stop_at;
        for (int phase = 0; phase < MASK_PHASES; phase++) begin
            case (phase)
                0: m = '0;
                1: m = '1;
                2: m = {4{64'h5555_aaaa_0f0f_f0f0}};
                3: m = {$urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom}
                     & {$urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom};
                default: m = {$urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom};
            endcase
            // One phase runs with both sides at full rate.
            no_idle = (phase == 4);
            set_masks(m);
            stop_at = words_sent + RANDOM_WORDS / MASK_PHASES;
            while (words_sent < stop_at) begin
                send_random_buffer();
            end
            settle();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        mask_copy = '0;
        restart_frame();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_frame_sequence();
        test_channel_error();
        test_buffer_cut();
        test_random_masks();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/apvd_pkg.sv
rtl/apvd_cfg.sv
rtl/apvd_decode.sv
rtl/apvd_outq.sv
rtl/apv_frame_stream_deframer_core.sv
rtl/apvd_checker.sv
tb/tb_apv_frame_stream_deframer_core.sv
